### rtl/mlfq_pkg.sv
// ----------------------------------------------------------------------------
// mlfq_pkg
// Shared types, codes and constants of the bitmap task scheduler.
// ----------------------------------------------------------------------------
package mlfq_pkg;

  localparam int MAX_TASKS = 32;

  typedef enum logic [2:0] {
    ST_UNUSED   = 3'd0,
    ST_READY    = 3'd1,
    ST_RUNNING  = 3'd2,
    ST_BLOCKED  = 3'd3,
    ST_ZOMBIE   = 3'd4,
    ST_SLEEPING = 3'd5
  } slot_state_e;

  typedef enum logic [2:0] {
    OP_TICK   = 3'd0,
    OP_CREATE = 3'd1,
    OP_SETPRI = 3'd2,
    OP_SLEEP  = 3'd3,
    OP_EXIT   = 3'd4,
    OP_WAKE   = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_NOSLOT = 2'd1,
    STAT_IGNORE = 2'd2
  } stat_e;

  typedef enum logic [2:0] {
    CFG_QUANTUM  = 3'd0,
    CFG_AGING    = 3'd1,
    CFG_REAP     = 3'd2,
    CFG_RT_PRIO  = 3'd3,
    CFG_IDLE_PRI = 3'd4,
    CFG_HK_PER   = 3'd5
  } cfg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_WAKE,
    S_TGT_RD,
    S_TGT_MW,
    S_PICK,
    S_DISP_RD,
    S_DISP_MW,
    S_CREATE,
    S_HK_CHK,
    S_HK,
    S_FIN
  } fsm_e;

  typedef struct packed {
    slot_state_e st;
    logic [7:0]  prio;
    logic [7:0]  base;
    logic [15:0] wait_cnt;
    logic [15:0] run_cnt;
    logic [31:0] deadline;
    logic [15:0] zombie_cnt;
  } slot_rec_t;

  localparam logic [7:0]  AGE_CAP = 8'd254;
  localparam logic [15:0] CNT_MAX = 16'hFFFF;

  localparam logic [15:0] QUANTUM_RST = 16'd10;
  localparam logic [15:0] AGING_RST   = 16'd100;
  localparam logic [15:0] REAP_RST    = 16'd10;
  localparam logic [7:0]  RT_PRIO_RST = 8'd200;
  localparam logic [7:0]  IDLE_RST    = 8'd0;
  localparam logic [15:0] HK_PER_RST  = 16'd50;

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    return (v == CNT_MAX) ? v : v + 16'd1;
  endfunction

endpackage

### rtl/mlfq_ram.sv
// ----------------------------------------------------------------------------
// mlfq_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module mlfq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### rtl/mlfq_rem.sv
// ----------------------------------------------------------------------------
// mlfq_rem
// Bit-serial remainder unit: tests whether a 32-bit value is a multiple of
// a 16-bit nonzero divisor, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module mlfq_rem (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [15:0] divisor_i,
  output logic        done_o,
  output logic        zero_o
);

  logic [15:0] rem_q, rem_d;
  logic [31:0] dvd_q, dvd_d;
  logic [15:0] dsr_q, dsr_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [16:0] trial;

  assign done_o = (cnt_q == 6'd32);
  assign zero_o = (rem_q == 16'd0);
  assign trial  = {rem_q, dvd_q[31]};

  always_comb begin
    rem_d = rem_q;
    dvd_d = dvd_q;
    dsr_d = dsr_q;
    cnt_d = cnt_q;
    if (start_i) begin
      rem_d = '0;
      dvd_d = dividend_i;
      dsr_d = divisor_i;
      cnt_d = '0;
    end else if (!done_o) begin
      if (trial >= {1'b0, dsr_q}) begin
        rem_d = 16'(trial - {1'b0, dsr_q});
      end else begin
        rem_d = trial[15:0];
      end
      dvd_d = {dvd_q[30:0], 1'b0};
      cnt_d = cnt_q + 6'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 6'd32;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    dsr_q <= dsr_d;
  end

endmodule

### rtl/mlfq_bitmap_task_scheduler.sv
// ----------------------------------------------------------------------------
// mlfq_bitmap_task_scheduler
// Multilevel-feedback priority task scheduler with round-robin pick, aging
// and zombie reaping. Slot records live in one RAM and are swept by a
// sequencer one slot per cycle.
//
//   Channel  Signals                              Direction
//   in       in_valid_i / in_stall_o + 4 fields   into the block
//   out      out_valid_o / out_stall_i + 4 fields out of the block
//   cfg      cfg_we_i, cfg_idx_i, cfg_data_i      into the block
//
// A tick runs a wake sweep, then a pick sweep unless the running slot keeps
// its quantum, then a housekeeping sweep when uptime is a multiple of the
// housekeeping period, each one slot per cycle through the single RAM read
// port; the remainder unit runs during the wake sweep and adds no wait.
// Per-slot valid bits give reset values at once; no clearing pass is needed.
// A new transaction is accepted while a result still waits on a stalled output.
// ----------------------------------------------------------------------------
module mlfq_bitmap_task_scheduler
  import mlfq_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  opcode_i,
  input  logic [4:0]  task_slot_i,
  input  logic [7:0]  new_priority_i,
  input  logic [15:0] sleep_ticks_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [4:0]  running_slot_o,
  output logic        switched_o,
  output logic [1:0]  status_o,
  output logic [4:0]  created_slot_o
);

  localparam int SW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CW = $clog2(MAX_TASKS + 1);
  localparam int RW = $bits(slot_rec_t);

  fsm_e state_q, state_d;

  logic [15:0] quantum_q, aging_q, reap_q, hk_per_q;
  logic [7:0]  rt_prio_q, idle_prio_q;

  logic [CW-1:0] cnt_q, cnt_d;
  op_e           op_q, op_d;
  logic [SW-1:0] tgt_q, tgt_d;
  logic [7:0]    prio_q, prio_d;
  logic [15:0]   ticks_q, ticks_d;
  logic [SW-1:0] cur_q, cur_d;
  logic [31:0]   uptime_q, uptime_d;
  logic          expire_q, expire_d;
  logic          found_q, found_d;
  logic [SW-1:0] best_q, best_d;
  logic [7:0]    bestp_q, bestp_d;
  logic          real_q, real_d;
  logic          sw_q, sw_d;
  stat_e         status_q, status_d;
  logic [SW-1:0] created_q, created_d;
  logic [SW-1:0] pidx_q, pidx_d;
  logic [SW-1:0] rd_addr_q;
  logic          rd_vld_q;
  logic [MAX_TASKS-1:0] vld_q;

  logic          out_valid_q;
  logic [4:0]    out_run_q, out_created_q;
  logic          out_sw_q;
  logic [1:0]    out_status_q;

  logic          ram_we;
  logic [SW-1:0] ram_waddr, ram_raddr;
  slot_rec_t     ram_wdata, ram_rdata, rec, rst_rec;
  logic [RW-1:0] ram_rdata_raw;

  logic          div_start, div_done, div_zero;
  logic [15:0]   period_eff;

  logic          accept, last, proc, load_out, oob;
  logic [15:0]   run_inc;
  logic          expire_now, tgt_ignore, cand, found_n, disp_real;
  logic [SW-1:0] best_n;
  logic [7:0]    bestp_n;

  function automatic logic [SW-1:0] wrap_inc(input logic [SW-1:0] a);
    return (a == SW'(MAX_TASKS - 1)) ? '0 : a + 1'b1;
  endfunction

  mlfq_ram #(
    .WIDTH(RW),
    .DEPTH(MAX_TASKS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata_raw)
  );

  assign period_eff = (hk_per_q == 16'd0) ? 16'd1 : hk_per_q;

  mlfq_rem u_rem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(uptime_d),
    .divisor_i (period_eff),
    .done_o    (div_done),
    .zero_o    (div_zero)
  );

  assign ram_rdata = slot_rec_t'(ram_rdata_raw);

  always_comb begin
    rst_rec    = '0;
    rst_rec.st = (rd_addr_q == '0) ? ST_RUNNING : ST_UNUSED;
    rec        = rd_vld_q ? ram_rdata : rst_rec;
  end

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign last       = (cnt_q == CW'(MAX_TASKS));
  assign proc       = (cnt_q != '0);
  assign load_out   = (state_q == S_FIN) && (!out_valid_q || !out_stall_i);
  assign oob        = (32'(task_slot_i) >= MAX_TASKS);

  assign run_inc    = sat_inc(rec.run_cnt);
  assign expire_now = (rec.st == ST_RUNNING) && (run_inc >= quantum_q);

  always_comb begin
    case (op_q)
      OP_SETPRI: tgt_ignore = (rec.st == ST_UNUSED);
      OP_WAKE:   tgt_ignore = !((rec.st == ST_SLEEPING) || (rec.st == ST_BLOCKED));
      OP_SLEEP:  tgt_ignore = (rec.st != ST_RUNNING) || (ticks_q == 16'd0);
      OP_EXIT:   tgt_ignore = (rec.st != ST_RUNNING);
      default:   tgt_ignore = 1'b0;
    endcase
  end

  assign cand      = proc && (rec.st == ST_READY) && (!found_q || (rec.prio > bestp_q));
  assign found_n   = found_q || cand;
  assign best_n    = cand ? rd_addr_q : best_q;
  assign bestp_n   = cand ? rec.prio : bestp_q;
  assign disp_real = expire_q ? (found_n && (best_n != cur_q)) : found_n;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (op_e'(opcode_i))
            OP_TICK:            state_d = S_WAKE;
            OP_CREATE:          state_d = S_CREATE;
            OP_SETPRI, OP_WAKE: state_d = oob ? S_FIN : S_TGT_RD;
            OP_SLEEP, OP_EXIT:  state_d = S_TGT_RD;
            default:            state_d = S_FIN;
          endcase
        end
      end
      S_WAKE: begin
        if (last) state_d = S_TGT_RD;
      end
      S_TGT_RD: state_d = S_TGT_MW;
      S_TGT_MW: begin
        case (op_q)
          OP_TICK:           state_d = (rec.st == ST_RUNNING && !expire_now) ? S_HK_CHK : S_PICK;
          OP_SLEEP, OP_EXIT: state_d = tgt_ignore ? S_FIN : S_PICK;
          default:           state_d = S_FIN;
        endcase
      end
      S_PICK: begin
        if (last) begin
          if (disp_real || expire_q) begin
            state_d = S_DISP_RD;
          end else begin
            state_d = (op_q == OP_TICK) ? S_HK_CHK : S_FIN;
          end
        end
      end
      S_DISP_RD: state_d = S_DISP_MW;
      S_DISP_MW: state_d = (op_q == OP_TICK) ? S_HK_CHK : S_FIN;
      S_CREATE: begin
        if (last) state_d = S_FIN;
      end
      S_HK_CHK: begin
        if (div_done) state_d = div_zero ? S_HK : S_FIN;
      end
      S_HK: begin
        if (last) state_d = S_FIN;
      end
      S_FIN: begin
        if (load_out) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cnt_d     = cnt_q;
    op_d      = op_q;
    tgt_d     = tgt_q;
    prio_d    = prio_q;
    ticks_d   = ticks_q;
    cur_d     = cur_q;
    uptime_d  = uptime_q;
    expire_d  = expire_q;
    found_d   = found_q;
    best_d    = best_q;
    bestp_d   = bestp_q;
    real_d    = real_q;
    sw_d      = sw_q;
    status_d  = status_q;
    created_d = created_q;
    pidx_d    = pidx_q;
    ram_we    = 1'b0;
    ram_waddr = rd_addr_q;
    ram_raddr = '0;
    ram_wdata = rec;
    div_start = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d      = op_e'(opcode_i);
          prio_d    = new_priority_i;
          ticks_d   = sleep_ticks_i;
          cnt_d     = '0;
          found_d   = 1'b0;
          sw_d      = 1'b0;
          created_d = '0;
          status_d  = STAT_OK;
          tgt_d     = SW'(task_slot_i);
          case (op_e'(opcode_i))
            OP_TICK: begin
              tgt_d     = cur_q;
              uptime_d  = uptime_q + 32'd1;
              div_start = 1'b1;
            end
            OP_CREATE: ;
            OP_SETPRI, OP_WAKE: begin
              if (oob) status_d = STAT_IGNORE;
            end
            OP_SLEEP, OP_EXIT: tgt_d = cur_q;
            default: status_d = STAT_IGNORE;
          endcase
        end
      end
      S_WAKE: begin
        if (!last) ram_raddr = cnt_q[SW-1:0];
        cnt_d = cnt_q + 1'b1;
        if (proc && rec.st == ST_SLEEPING && uptime_q >= rec.deadline) begin
          ram_we       = 1'b1;
          ram_wdata.st = ST_READY;
        end
      end
      S_TGT_RD: ram_raddr = tgt_q;
      S_TGT_MW: begin
        ram_waddr = tgt_q;
        cnt_d     = '0;
        found_d   = 1'b0;
        pidx_d    = wrap_inc(cur_q);
        expire_d  = 1'b0;
        case (op_q)
          OP_SETPRI: begin
            if (tgt_ignore) begin
              status_d = STAT_IGNORE;
            end else begin
              ram_we         = 1'b1;
              ram_wdata.prio = prio_q;
              ram_wdata.base = prio_q;
            end
          end
          OP_WAKE: begin
            if (tgt_ignore) begin
              status_d = STAT_IGNORE;
            end else begin
              ram_we             = 1'b1;
              ram_wdata.deadline = '0;
              ram_wdata.st       = ST_READY;
            end
          end
          OP_SLEEP: begin
            if (tgt_ignore) begin
              status_d = STAT_IGNORE;
            end else begin
              ram_we             = 1'b1;
              ram_wdata.deadline = uptime_q + {16'd0, ticks_q};
              ram_wdata.st       = ST_SLEEPING;
            end
          end
          OP_EXIT: begin
            if (tgt_ignore) begin
              status_d = STAT_IGNORE;
            end else begin
              ram_we               = 1'b1;
              ram_wdata.zombie_cnt = '0;
              ram_wdata.st         = ST_ZOMBIE;
            end
          end
          OP_TICK: begin
            if (rec.st == ST_RUNNING) begin
              ram_we   = 1'b1;
              expire_d = expire_now;
              if (expire_now) begin
                ram_wdata.run_cnt = '0;
                ram_wdata.st      = ST_READY;
                if (rec.prio > idle_prio_q && rec.base < rt_prio_q && rec.prio > 8'd1) begin
                  ram_wdata.prio = rec.prio - 8'd1;
                end
              end else begin
                ram_wdata.run_cnt = run_inc;
              end
            end
          end
          default: ;
        endcase
      end
      S_PICK: begin
        if (!last) begin
          ram_raddr = pidx_q;
          pidx_d    = wrap_inc(pidx_q);
        end
        cnt_d   = cnt_q + 1'b1;
        found_d = found_n;
        best_d  = best_n;
        bestp_d = bestp_n;
        if (last) begin
          tgt_d  = disp_real ? best_n : cur_q;
          real_d = disp_real;
        end
      end
      S_DISP_RD: ram_raddr = tgt_q;
      S_DISP_MW: begin
        ram_we       = 1'b1;
        ram_waddr    = tgt_q;
        ram_wdata.st = ST_RUNNING;
        if (real_q) begin
          ram_wdata.wait_cnt = '0;
          cur_d              = tgt_q;
          sw_d               = 1'b1;
        end
      end
      S_CREATE: begin
        if (!last) ram_raddr = cnt_q[SW-1:0];
        cnt_d = cnt_q + 1'b1;
        if (proc && rec.st == ST_UNUSED && !found_q) begin
          ram_we               = 1'b1;
          ram_wdata.st         = ST_READY;
          ram_wdata.prio       = prio_q;
          ram_wdata.base       = prio_q;
          ram_wdata.wait_cnt   = '0;
          ram_wdata.run_cnt    = '0;
          ram_wdata.deadline   = '0;
          ram_wdata.zombie_cnt = '0;
          found_d              = 1'b1;
          created_d            = rd_addr_q;
        end
        if (last) begin
          status_d = (found_q || (proc && rec.st == ST_UNUSED)) ? STAT_OK : STAT_NOSLOT;
        end
      end
      S_HK_CHK: cnt_d = '0;
      S_HK: begin
        if (!last) ram_raddr = cnt_q[SW-1:0];
        cnt_d = cnt_q + 1'b1;
        if (proc && rec.st == ST_READY) begin
          ram_we             = 1'b1;
          ram_wdata.wait_cnt = sat_inc(rec.wait_cnt);
          if (sat_inc(rec.wait_cnt) >= aging_q && rec.prio < AGE_CAP) begin
            ram_wdata.prio     = rec.prio + 8'd1;
            ram_wdata.wait_cnt = '0;
          end
        end else if (proc && rec.st == ST_ZOMBIE) begin
          ram_we               = 1'b1;
          ram_wdata.zombie_cnt = sat_inc(rec.zombie_cnt);
          if (sat_inc(rec.zombie_cnt) >= reap_q) begin
            ram_wdata.st = ST_UNUSED;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cur_q       <= '0;
      uptime_q    <= '0;
      vld_q       <= '0;
      out_valid_q <= 1'b0;
      quantum_q   <= QUANTUM_RST;
      aging_q     <= AGING_RST;
      reap_q      <= REAP_RST;
      rt_prio_q   <= RT_PRIO_RST;
      idle_prio_q <= IDLE_RST;
      hk_per_q    <= HK_PER_RST;
    end else begin
      state_q  <= state_d;
      cur_q    <= cur_d;
      uptime_q <= uptime_d;
      if (ram_we) vld_q[ram_waddr] <= 1'b1;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_QUANTUM:  quantum_q   <= cfg_data_i;
          CFG_AGING:    aging_q     <= cfg_data_i;
          CFG_REAP:     reap_q      <= cfg_data_i;
          CFG_RT_PRIO:  rt_prio_q   <= cfg_data_i[7:0];
          CFG_IDLE_PRI: idle_prio_q <= cfg_data_i[7:0];
          CFG_HK_PER:   hk_per_q    <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q     <= cnt_d;
    op_q      <= op_d;
    tgt_q     <= tgt_d;
    prio_q    <= prio_d;
    ticks_q   <= ticks_d;
    expire_q  <= expire_d;
    found_q   <= found_d;
    best_q    <= best_d;
    bestp_q   <= bestp_d;
    real_q    <= real_d;
    sw_q      <= sw_d;
    status_q  <= status_d;
    created_q <= created_d;
    pidx_q    <= pidx_d;
    rd_addr_q <= ram_raddr;
    rd_vld_q  <= vld_q[ram_raddr];
    if (load_out) begin
      out_run_q     <= 5'(cur_q);
      out_sw_q      <= sw_q;
      out_status_q  <= status_q;
      out_created_q <= 5'(created_q);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign running_slot_o = out_run_q;
  assign switched_o     = out_sw_q;
  assign status_o       = out_status_q;
  assign created_slot_o = out_created_q;

endmodule

### rtl/mlfq_chk.sv
// ----------------------------------------------------------------------------
// mlfq_chk
// Port-level checker for the bitmap task scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module mlfq_chk
  import mlfq_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [4:0] running_slot_o,
  input logic       switched_o,
  input logic [1:0] status_o,
  input logic [4:0] created_slot_o
);

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("Block took a second transaction while busy.");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(running_slot_o)
      && $stable(status_o) && $stable(switched_o)))
    else $error("Stalled result changed.");

  a_switch_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && switched_o) |-> (status_o == STAT_OK))
    else $error("Task switch reported on a failed request.");

  a_created_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && created_slot_o != 5'd0) |-> (status_o == STAT_OK))
    else $error("Created slot reported on a failed request.");

endmodule

bind mlfq_bitmap_task_scheduler mlfq_chk u_mlfq_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .running_slot_o(running_slot_o),
  .switched_o    (switched_o),
  .status_o      (status_o),
  .created_slot_o(created_slot_o)
);

### test/mlfq_bitmap_task_scheduler_test.sv
// ----------------------------------------------------------------------------
// mlfq_bitmap_task_scheduler_test
// Self-checking testbench of the bitmap task scheduler. A behavioral model
// of the slot table predicts every result; directed and random operation
// streams run under several register settings with random idling on both
// channels.
// ----------------------------------------------------------------------------

class sched_scoreboard;
  typedef struct packed {
    logic [4:0] running;
    logic       switched;
    logic [1:0] status;
    logic [4:0] created;
  } sched_result_t;

  logic [2:0]  st[32];
  logic [7:0]  prio[32];
  logic [7:0]  base[32];
  logic [15:0] wait_cnt[32];
  logic [15:0] run_cnt[32];
  logic [31:0] deadline[32];
  logic [15:0] zombie_cnt[32];
  logic [4:0]  cur;
  logic [31:0] uptime;
  logic [15:0] quantum, aging, reap, period;
  logic [7:0]  rt_prio, idle_prio;
  sched_result_t pending[$];
  int errors;

  function new();
    errors = 0;
    for (int i = 0; i < 32; i++) begin
      st[i] = mlfq_pkg::ST_UNUSED;
      prio[i] = 0;
      base[i] = 0;
      wait_cnt[i] = 0;
      run_cnt[i] = 0;
      deadline[i] = 0;
      zombie_cnt[i] = 0;
    end
    st[0] = mlfq_pkg::ST_RUNNING;
    cur = 0;
    uptime = 0;
    quantum = 10;
    aging = 100;
    reap = 10;
    rt_prio = 200;
    idle_prio = 0;
    period = 50;
  endfunction

  function void write_reg(logic [2:0] idx, logic [15:0] val);
    case (idx)
      mlfq_pkg::CFG_QUANTUM: quantum = val;
      mlfq_pkg::CFG_AGING: aging = val;
      mlfq_pkg::CFG_REAP: reap = val;
      mlfq_pkg::CFG_RT_PRIO: rt_prio = val[7:0];
      mlfq_pkg::CFG_IDLE_PRI: idle_prio = val[7:0];
      mlfq_pkg::CFG_HK_PER: period = val;
      default: ;
    endcase
  endfunction

  function logic [15:0] bump(logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function int best_ready();
    int top;
    int idx;
    top = -1;
    for (int i = 0; i < 32; i++)
      if (st[i] == mlfq_pkg::ST_READY && int'(prio[i]) > top) top = prio[i];
    if (top < 0) return -1;
    for (int i = 1; i <= 32; i++) begin
      idx = (cur + i) % 32;
      if (st[idx] == mlfq_pkg::ST_READY && prio[idx] == top) return idx;
    end
    return -1;
  endfunction

  function void run_slot(int n);
    st[n] = mlfq_pkg::ST_RUNNING;
    wait_cnt[n] = 0;
    cur = n[4:0];
  endfunction

  function void housekeep();
    for (int i = 0; i < 32; i++) begin
      if (st[i] == mlfq_pkg::ST_READY) begin
        wait_cnt[i] = bump(wait_cnt[i]);
        if (wait_cnt[i] >= aging && prio[i] < 8'd254) begin
          prio[i]++;
          wait_cnt[i] = 0;
        end
      end else if (st[i] == mlfq_pkg::ST_ZOMBIE) begin
        zombie_cnt[i] = bump(zombie_cnt[i]);
        if (zombie_cnt[i] >= reap) st[i] = mlfq_pkg::ST_UNUSED;
      end
    end
  endfunction

  function logic tick();
    logic sw;
    int c;
    int n;
    logic [31:0] per;
    sw = 0;
    c = cur;
    per = (period == 0) ? 32'd1 : {16'd0, period};
    uptime++;
    for (int i = 0; i < 32; i++)
      if (st[i] == mlfq_pkg::ST_SLEEPING && uptime >= deadline[i]) st[i] = mlfq_pkg::ST_READY;
    if (st[c] == mlfq_pkg::ST_RUNNING) begin
      run_cnt[c] = bump(run_cnt[c]);
      if (run_cnt[c] >= quantum) begin
        if (prio[c] > idle_prio && base[c] < rt_prio && prio[c] > 1) prio[c]--;
        run_cnt[c] = 0;
        st[c] = mlfq_pkg::ST_READY;
        n = best_ready();
        if (n < 0 || n == c) st[c] = mlfq_pkg::ST_RUNNING;
        else begin
          run_slot(n);
          sw = 1;
        end
      end
    end else begin
      n = best_ready();
      if (n >= 0) begin
        run_slot(n);
        sw = 1;
      end
    end
    if (uptime % per == 0) housekeep();
    return sw;
  endfunction

  function void note_input(logic [2:0] op, logic [4:0] slot, logic [7:0] np,
                           logic [15:0] ticks);
    sched_result_t r;
    int i;
    int n;
    r = '0;
    case (op)
      mlfq_pkg::OP_TICK: r.switched = tick();
      mlfq_pkg::OP_CREATE: begin
        for (i = 0; i < 32; i++) if (st[i] == mlfq_pkg::ST_UNUSED) break;
        if (i >= 32) r.status = mlfq_pkg::STAT_NOSLOT;
        else begin
          st[i] = mlfq_pkg::ST_READY;
          prio[i] = np;
          base[i] = np;
          wait_cnt[i] = 0;
          run_cnt[i] = 0;
          deadline[i] = 0;
          zombie_cnt[i] = 0;
          r.created = i[4:0];
        end
      end
      mlfq_pkg::OP_SETPRI: begin
        if (st[slot] == mlfq_pkg::ST_UNUSED) r.status = mlfq_pkg::STAT_IGNORE;
        else begin
          prio[slot] = np;
          base[slot] = np;
        end
      end
      mlfq_pkg::OP_SLEEP, mlfq_pkg::OP_EXIT: begin
        if (st[cur] != mlfq_pkg::ST_RUNNING || (op == mlfq_pkg::OP_SLEEP && ticks == 0))
          r.status = mlfq_pkg::STAT_IGNORE;
        else begin
          if (op == mlfq_pkg::OP_SLEEP) begin
            deadline[cur] = uptime + ticks;
            st[cur] = mlfq_pkg::ST_SLEEPING;
          end else begin
            st[cur] = mlfq_pkg::ST_ZOMBIE;
            zombie_cnt[cur] = 0;
          end
          n = best_ready();
          if (n >= 0) begin
            run_slot(n);
            r.switched = 1;
          end
        end
      end
      mlfq_pkg::OP_WAKE: begin
        if (st[slot] != mlfq_pkg::ST_SLEEPING && st[slot] != mlfq_pkg::ST_BLOCKED)
          r.status = mlfq_pkg::STAT_IGNORE;
        else begin
          deadline[slot] = 0;
          st[slot] = mlfq_pkg::ST_READY;
        end
      end
      default: r.status = mlfq_pkg::STAT_IGNORE;
    endcase
    r.running = cur;
    pending.push_back(r);
  endfunction

  task report(string what, int got, int want);
    $display("mismatch: %s got %0d expected %0d", what, got, want);
    errors++;
  endtask

  task check_result(logic [4:0] rs, logic sw, logic [1:0] stat, logic [4:0] cs);
    sched_result_t e;
    if (pending.size() == 0) begin
      report("unexpected transaction, running_slot", rs, -1);
      return;
    end
    e = pending.pop_front();
    if (rs !== e.running) report("running_slot", rs, e.running);
    if (sw !== e.switched) report("switched", sw, e.switched);
    if (stat !== e.status) report("status", stat, e.status);
    if (cs !== e.created) report("created_slot", cs, e.created);
  endtask
endclass

module mlfq_bitmap_task_scheduler_test;
  import mlfq_pkg::*;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        cfg_we_i = 0;
  logic [2:0]  cfg_idx_i = 0;
  logic [15:0] cfg_data_i = 0;
  logic        in_valid_i = 0;
  logic        in_stall_o;
  logic [2:0]  opcode_i = 0;
  logic [4:0]  task_slot_i = 0;
  logic [7:0]  new_priority_i = 0;
  logic [15:0] sleep_ticks_i = 0;
  logic        out_valid_o;
  logic        out_stall_i = 0;
  logic [4:0]  running_slot_o;
  logic        switched_o;
  logic [1:0]  status_o;
  logic [4:0]  created_slot_o;

  sched_scoreboard sched = new();
  bit quiet;
  int stall_left;

  mlfq_bitmap_task_scheduler dut (.*);

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sched.check_result(running_slot_o, switched_o, status_o, created_slot_o);
    if (quiet || stall_left == 0) begin
      out_stall_i <= !quiet && ($urandom_range(0, 5) == 0);
      stall_left = $urandom_range(1, 10);
    end else stall_left--;
  end

  task automatic send_op(logic [2:0] op, logic [4:0] slot, logic [7:0] np, logic [15:0] ticks);
    if (!quiet && $urandom_range(0, 5) == 0) repeat ($urandom_range(1, 10)) @(posedge clk_i);
    in_valid_i <= 1;
    opcode_i <= op;
    task_slot_i <= slot;
    new_priority_i <= np;
    sleep_ticks_i <= ticks;
    do @(posedge clk_i); while (in_stall_o);
    sched.note_input(op, slot, np, ticks);
    in_valid_i <= 0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    while (sched.pending.size() != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
  endtask

  task automatic write_cfg(cfg_idx_e idx, logic [15:0] val);
    cfg_we_i <= 1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 0;
    sched.write_reg(idx, val);
    @(posedge clk_i);
  endtask

  task automatic random_op();
    int k;
    logic [15:0] t;
    k = $urandom_range(0, 99);
    t = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40));
    if (k < 45) send_op(OP_TICK, 5'($urandom), 8'($urandom), 16'($urandom));
    else if (k < 58) send_op(OP_CREATE, 5'($urandom), 8'($urandom_range(0, 255)), t);
    else if (k < 66) send_op(OP_SETPRI, 5'($urandom), 8'($urandom), t);
    else if (k < 76) send_op(OP_SLEEP, 5'($urandom), 8'($urandom), t);
    else if (k < 84) send_op(OP_EXIT, 5'($urandom), 8'($urandom), t);
    else if (k < 96) send_op(OP_WAKE, 5'($urandom), 8'($urandom), t);
    else send_op(3'($urandom_range(6, 7)), 5'($urandom), 8'($urandom), 16'($urandom));
  endtask

  initial begin
    #2000000000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    quiet = 0;
    stall_left = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    send_op(OP_EXIT, 0, 0, 0);
    send_op(OP_SLEEP, 0, 0, 5);
    send_op(OP_TICK, 0, 0, 0);
    send_op(OP_CREATE, 31, 255, 16'hFFFF);
    send_op(OP_CREATE, 0, 0, 0);
    send_op(OP_CREATE, 0, 254, 0);
    send_op(OP_SETPRI, 31, 7, 0);
    send_op(OP_SETPRI, 2, 128, 0);
    send_op(OP_WAKE, 1, 0, 0);
    send_op(OP_SLEEP, 0, 0, 0);
    send_op(OP_SLEEP, 0, 0, 16'hFFFF);
    send_op(OP_SLEEP, 0, 0, 1);
    send_op(OP_TICK, 0, 0, 0);
    send_op(OP_TICK, 0, 0, 0);
    send_op(OP_EXIT, 0, 0, 0);
    send_op(3'd6, 5'h1F, 8'hFF, 16'hFFFF);
    send_op(3'd7, 0, 0, 0);
    repeat (34) send_op(OP_CREATE, 0, 8'($urandom), 0);
    drain();
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_cfg(CFG_QUANTUM, 1); write_cfg(CFG_AGING, 1); write_cfg(CFG_REAP, 1);
          write_cfg(CFG_RT_PRIO, 255); write_cfg(CFG_IDLE_PRI, 0); write_cfg(CFG_HK_PER, 1);
        end
        1: begin
          write_cfg(CFG_QUANTUM, 0); write_cfg(CFG_HK_PER, 0); write_cfg(CFG_RT_PRIO, 0);
          write_cfg(CFG_IDLE_PRI, 255);
        end
        2: begin
          write_cfg(CFG_QUANTUM, 16'hFFFF); write_cfg(CFG_AGING, 16'hFFFF);
          write_cfg(CFG_REAP, 16'hFFFF); write_cfg(CFG_HK_PER, 16'hFFFF);
          write_cfg(CFG_RT_PRIO, 100); write_cfg(CFG_IDLE_PRI, 20);
        end
        default: begin
          write_cfg(CFG_QUANTUM, 16'($urandom_range(0, 8)));
          write_cfg(CFG_AGING, 16'($urandom_range(0, 4)));
          write_cfg(CFG_REAP, 16'($urandom_range(0, 4)));
          write_cfg(CFG_RT_PRIO, 16'($urandom_range(0, 255)));
          write_cfg(CFG_IDLE_PRI, 16'($urandom_range(0, 40)));
          write_cfg(CFG_HK_PER, 16'($urandom_range(0, 6)));
        end
      endcase
      if (ph == 5) quiet = 1;
      repeat (250) random_op();
      drain();
    end
    if (sched.errors == 0 && sched.pending.size() == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule
